[hw/rtl/at_rlc_pkg.sv]
// Shared definitions for the AT response line classifier.
// Holds the result word type, code constants and the fixed response patterns.
// No dependencies.
package at_rlc_pkg;

  localparam int LINE_BYTES_DEF   = 256;
  localparam int URC_SLOTS_DEF    = 4;
  localparam int PREFIX_BYTES_DEF = 8;

  localparam int NFIX         = 6;
  localparam int FIX_MAX      = 16;
  localparam int PREFIX_REGS  = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] KIND_RAW   = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_CLASS = 2'd2;

  localparam logic [2:0] CLS_OK         = 3'd0;
  localparam logic [2:0] CLS_ERROR      = 3'd1;
  localparam logic [2:0] CLS_CONNECT    = 3'd2;
  localparam logic [2:0] CLS_NO_CARRIER = 3'd3;
  localparam logic [2:0] CLS_URC        = 3'd4;
  localparam logic [2:0] CLS_RESPONSE   = 3'd5;

  localparam logic [2:0] REG_DATA_MODE  = 3'd0;
  localparam logic [2:0] REG_SLOTS_USED = 3'd1;
  localparam logic [2:0] REG_PREFIX_0   = 3'd2;

  localparam logic [3:0] FIX_LEN [NFIX] = '{4'd2, 4'd5, 4'd11, 4'd11, 4'd7, 4'd10};
  localparam logic       FIX_EXACT [NFIX] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam logic [2:0] FIX_CLASS [NFIX] =
    '{CLS_OK, CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_CONNECT, CLS_NO_CARRIER};

  localparam logic [7:0] FIX_CHARS [NFIX][FIX_MAX] = '{
    '{0: "O", 1: "K", default: 8'h00},
    '{0: "E", 1: "R", 2: "R", 3: "O", 4: "R", default: 8'h00},
    '{0: "+", 1: "C", 2: "M", 3: "E", 4: " ", 5: "E", 6: "R", 7: "R", 8: "O",
      9: "R", 10: ":", default: 8'h00},
    '{0: "+", 1: "C", 2: "M", 3: "S", 4: " ", 5: "E", 6: "R", 7: "R", 8: "O",
      9: "R", 10: ":", default: 8'h00},
    '{0: "C", 1: "O", 2: "N", 3: "N", 4: "E", 5: "C", 6: "T", default: 8'h00},
    '{0: "N", 1: "O", 2: " ", 3: "C", 4: "A", 5: "R", 6: "R", 7: "I", 8: "E",
      9: "R", default: 8'h00}
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] cls;
    logic [1:0] slot;
    logic [7:0] length;
    logic       last;
  } rlc_word_t;

endpackage

[hw/rtl/at_rlc_queue.sv]
// Result queue of the AT response line classifier: takes up to two words per
// cycle and hands out one. Depends on at_rlc_pkg for the word type and depth.
module at_rlc_queue (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic [1:0]                                  push_cnt,
  input  at_rlc_pkg::rlc_word_t                       push_a,
  input  at_rlc_pkg::rlc_word_t                       push_b,
  input  logic                                        pop,
  output at_rlc_pkg::rlc_word_t                       head,
  output logic [$clog2(at_rlc_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(at_rlc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(at_rlc_pkg::QUEUE_DEPTH + 1);

  at_rlc_pkg::rlc_word_t mem [at_rlc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wp_inc;

  assign wp_inc = wp_r + PTR_W'(1);

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push_cnt);
    rp_nxt  = pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wp_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wp_inc] <= push_b;
    end
  end

  assign head  = mem[rp_r];
  assign count = cnt_r;

endmodule

[hw/rtl/at_response_line_classifier.sv]
// Top level of the AT response line classifier: line gathering, incremental
// pattern matching and classing. Depends on at_rlc_pkg and at_rlc_queue.
//
// Received modem bytes arrive one word at a time on the in_ channel
// (in_valid / in_stall). Results leave on the out_ channel (out_valid /
// out_stall) as raw data bytes, line bytes or end-of-line class words.
// Registers are written through cfg_we / cfg_index / cfg_wdata; write them
// only while idle; the block does not enforce this. Each accepted byte
// is processed in the cycle it is taken and its results are written to a
// four-word result queue, so the first result is visible in the cycle after
// acceptance. It takes one byte per cycle while in_stall is low; an LF
// that also releases the held last byte produces two words. The input stalls
// when fewer than two queue entries are free, so a stalled receiver backs up
// into in_stall, and no word is lost or reordered. Reset clears the line
// state, the queue and all registers; the prefix slots reset to empty.
module at_response_line_classifier #(
  parameter int LINE_BYTES   = at_rlc_pkg::LINE_BYTES_DEF,
  parameter int URC_SLOTS    = at_rlc_pkg::URC_SLOTS_DEF,
  parameter int PREFIX_BYTES = at_rlc_pkg::PREFIX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_line_class,
  output logic [1:0]  out_urc_slot,
  output logic [7:0]  out_line_length,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int CNT_W = $clog2(LINE_BYTES);
  localparam int QCNT_W = $clog2(at_rlc_pkg::QUEUE_DEPTH + 1);

  logic                 data_mode_r;
  logic [2:0]           slots_used_r;
  logic [63:0]          prefix_r [URC_SLOTS];

  logic [7:0]           held_r, held_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic [CNT_W-1:0]     line_cnt_r, line_cnt_nxt;
  logic [at_rlc_pkg::NFIX-1:0] fix_flags_r, fix_flags_nxt, fix_m;
  logic [URC_SLOTS-1:0] urc_flags_r, urc_flags_nxt, urc_m;

  logic [3:0]           plen [URC_SLOTS];
  logic [CNT_W-1:0]     pos;
  logic                 accept;
  logic                 emit_held;
  logic [1:0]           push_cnt;
  at_rlc_pkg::rlc_word_t push_a, push_b, line_word, class_word, head;
  logic [QCNT_W-1:0]    q_cnt;

  logic [at_rlc_pkg::NFIX-1:0] cls_fix;
  logic [URC_SLOTS-1:0]        cls_urc;
  logic [CNT_W-1:0]            len;
  logic                        found;
  logic [2:0]                  cls;
  logic [1:0]                  slot;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_cnt > QCNT_W'(at_rlc_pkg::QUEUE_DEPTH - 2);
  assign pos      = line_cnt_r - CNT_W'(1);
  assign emit_held = held_valid_r && (line_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_mode_r  <= 1'b0;
      slots_used_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == at_rlc_pkg::REG_DATA_MODE) begin
        data_mode_r <= cfg_wdata[0];
      end
      if (cfg_index == at_rlc_pkg::REG_SLOTS_USED) begin
        slots_used_r <= cfg_wdata[2:0];
      end
    end
  end

  for (genvar s = 0; s < URC_SLOTS; s++) begin : g_prefix
    if (s < at_rlc_pkg::PREFIX_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          prefix_r[s] <= '0;
        end else if (cfg_we && cfg_index == at_rlc_pkg::REG_PREFIX_0 + 3'(s)) begin
          prefix_r[s] <= cfg_wdata;
        end
      end
    end else begin : g_const
      assign prefix_r[s] = '0;
    end
  end

  always_comb begin
    for (int s = 0; s < URC_SLOTS; s++) begin
      plen[s] = 4'(PREFIX_BYTES);
      for (int k = PREFIX_BYTES - 1; k >= 0; k--) begin
        if (prefix_r[s][8*k +: 8] == 8'h00) begin
          plen[s] = 4'(k);
        end
      end
    end
  end

  always_comb begin
    fix_m = fix_flags_r;
    for (int i = 0; i < at_rlc_pkg::NFIX; i++) begin
      if (pos < CNT_W'(at_rlc_pkg::FIX_LEN[i]) &&
          at_rlc_pkg::FIX_CHARS[i][pos[3:0]] != held_r) begin
        fix_m[i] = 1'b0;
      end
    end
    urc_m = urc_flags_r;
    for (int s = 0; s < URC_SLOTS; s++) begin
      if (pos < CNT_W'(plen[s]) && prefix_r[s][{pos[2:0], 3'b000} +: 8] != held_r) begin
        urc_m[s] = 1'b0;
      end
    end
  end

  // At LF the held byte is matched first unless it is the stripped CR.
  always_comb begin
    if (emit_held && held_r != at_rlc_pkg::CH_CR) begin
      cls_fix = fix_m;
      cls_urc = urc_m;
      len     = line_cnt_r;
    end else begin
      cls_fix = fix_flags_r;
      cls_urc = urc_flags_r;
      len     = emit_held ? line_cnt_r - CNT_W'(1) : line_cnt_r;
    end
    found = 1'b0;
    cls   = at_rlc_pkg::CLS_RESPONSE;
    slot  = 2'd0;
    for (int i = 0; i < at_rlc_pkg::NFIX; i++) begin
      if (!found && cls_fix[i] &&
          (at_rlc_pkg::FIX_EXACT[i] ? (len == CNT_W'(at_rlc_pkg::FIX_LEN[i]))
                                    : (len >= CNT_W'(at_rlc_pkg::FIX_LEN[i])))) begin
        found = 1'b1;
        cls   = at_rlc_pkg::FIX_CLASS[i];
      end
    end
    for (int s = 0; s < URC_SLOTS; s++) begin
      if (!found && s < int'(slots_used_r) && cls_urc[s] && len >= CNT_W'(plen[s])) begin
        found = 1'b1;
        cls   = at_rlc_pkg::CLS_URC;
        slot  = 2'(s);
      end
    end
  end

  always_comb begin
    line_word      = '0;
    line_word.kind = at_rlc_pkg::KIND_LINE;
    line_word.data = held_r;
    line_word.last = 1'b1;

    class_word        = '0;
    class_word.kind   = at_rlc_pkg::KIND_CLASS;
    class_word.cls    = cls;
    class_word.slot   = slot;
    class_word.length = 8'(len);
    class_word.last   = 1'b1;

    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    line_cnt_nxt   = line_cnt_r;
    fix_flags_nxt  = fix_flags_r;
    urc_flags_nxt  = urc_flags_r;
    push_cnt       = 2'd0;
    push_a         = line_word;
    push_b         = class_word;

    if (accept) begin
      if (data_mode_r) begin
        push_a      = '0;
        push_a.kind = at_rlc_pkg::KIND_RAW;
        push_a.data = in_rx_byte;
        push_a.last = 1'b1;
        push_cnt    = 2'd1;
      end else if (in_rx_byte == at_rlc_pkg::CH_LF) begin
        if (emit_held && held_r != at_rlc_pkg::CH_CR) begin
          push_a.last = (len == '0);
          push_cnt    = (len != '0) ? 2'd2 : 2'd1;
        end else if (len != '0) begin
          push_a   = class_word;
          push_cnt = 2'd1;
        end
        held_nxt       = 8'h00;
        held_valid_nxt = 1'b0;
        line_cnt_nxt   = '0;
        fix_flags_nxt  = '1;
        urc_flags_nxt  = '1;
      end else if (in_rx_byte != at_rlc_pkg::CH_CR || line_cnt_r != '0) begin
        if (line_cnt_r < CNT_W'(LINE_BYTES - 1)) begin
          if (emit_held) begin
            fix_flags_nxt = fix_m;
            urc_flags_nxt = urc_m;
            push_cnt      = 2'd1;
          end
          held_nxt       = in_rx_byte;
          held_valid_nxt = 1'b1;
          line_cnt_nxt   = line_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 8'h00;
      held_valid_r <= 1'b0;
      line_cnt_r   <= '0;
      fix_flags_r  <= '1;
      urc_flags_r  <= '1;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      line_cnt_r   <= line_cnt_nxt;
      fix_flags_r  <= fix_flags_nxt;
      urc_flags_r  <= urc_flags_nxt;
    end
  end

  at_rlc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (push_b),
    .pop      (out_valid && !out_stall),
    .head     (head),
    .count    (q_cnt)
  );

  assign out_valid       = q_cnt != '0;
  assign out_item_kind   = head.kind;
  assign out_byte        = head.data;
  assign out_line_class  = head.cls;
  assign out_urc_slot    = head.slot;
  assign out_line_length = head.length;
  assign out_last        = head.last;

  a_held_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> line_cnt_r != '0)
    else $error("Held byte without a counted line byte.");

  a_class_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == at_rlc_pkg::KIND_CLASS |-> out_last)
    else $error("Class word is not the final word of its byte.");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= QCNT_W'(at_rlc_pkg::QUEUE_DEPTH))
    else $error("Result queue overflow.");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |=> out_valid)
    else $error("Queued result word is not visible on the next cycle.");

endmodule
